[design/htb_pkg.sv]
//------------------------------------------------------------------------------
// htb_pkg
// Shared types and constants for the Huffman tree builder.
//------------------------------------------------------------------------------
package htb_pkg;

    localparam int SYMBOLS     = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int SYM_W       = 8;
    localparam int ID_W        = 9;
    localparam int CNT_W       = 9;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [ID_W-1:0]        t_id;

    typedef enum logic [1:0] {
        FUNC_COUNT = 2'd0,
        FUNC_BUILD = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN_RD,
        ST_SCAN,
        ST_INS_RD,
        ST_INS,
        ST_M_RD0,
        ST_M_RD1,
        ST_M_POP,
        ST_M_FIND,
        ST_M_SHIFT_RD,
        ST_M_SHIFT,
        ST_M_TAIL_RD,
        ST_M_TAIL,
        ST_CLEAR,
        ST_DONE,
        ST_READ,
        ST_READ_OUT
    } t_state;

endpackage

[design/huffman_tree_builder.sv]
//------------------------------------------------------------------------------
// huffman_tree_builder
// Byte histogram with a sequential Huffman tree build over memories.
//------------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         i_start, o_busy, i_func, i_data_byte, i_node_index
// result    out        o_valid, o_left_child .. o_overflow
//
// A count item is a histogram read, then the write back.
// A read item passes through the node memory read.
// A build is quadratic in the leaf count: a sorted insertion per symbol and
// a search plus shift per merge, one queue entry at a time, followed by a
// histogram clearing sweep over all 256 entries. Reset is synchronous and
// active low. After reset the same sweep clears the histogram before any
// item is taken. Results are strobed for one cycle and cannot be stalled.
module huffman_tree_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_node_index,
    output logic       o_valid,
    output logic [8:0] o_left_child,
    output logic [8:0] o_right_child,
    output logic [31:0] o_weight,
    output logic [8:0] o_leaf_count,
    output logic [8:0] o_root_node,
    output logic       o_overflow
);

    localparam int QW = htb_pkg::ID_W + htb_pkg::COUNT_WIDTH;
    localparam int NW = 2 * htb_pkg::ID_W + htb_pkg::COUNT_WIDTH;

    // Memories.
    htb_pkg::t_count    hist_mem [htb_pkg::SYMBOLS];
    logic [QW-1:0]      q_mem    [htb_pkg::SYMBOLS];
    logic [NW-1:0]      node_mem [htb_pkg::SYMBOLS];

    logic               h_we;
    logic [7:0]         h_waddr, h_raddr;
    htb_pkg::t_count    h_wdata, r_h_rdata;
    logic               q_we;
    logic [7:0]         q_waddr, q_raddr;
    logic [QW-1:0]      q_wdata, r_q_rdata;
    logic               nd_we;
    logic [7:0]         nd_waddr, nd_raddr;
    logic [NW-1:0]      nd_wdata, r_nd_rdata;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hist_mem[h_waddr] <= h_wdata;
        end
        r_h_rdata <= hist_mem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        r_q_rdata <= q_mem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            node_mem[nd_waddr] <= nd_wdata;
        end
        r_nd_rdata <= node_mem[nd_raddr];
    end

    htb_pkg::t_state r_state, n_state;
    logic [8:0]       r_sym, n_sym;        // scan symbol / clear address
    logic [8:0]       r_qlen, n_qlen;
    logic [8:0]       r_i, n_i;            // insertion / search index
    logic [8:0]       r_leaves, n_leaves;
    logic [8:0]       r_icnt, n_icnt;
    htb_pkg::t_count  r_total, n_total;
    logic             r_ovf, n_ovf;
    htb_pkg::t_count  r_w, n_w;            // item weight being inserted
    htb_pkg::t_id     r_id, n_id;
    htb_pkg::t_id     r_left, n_left;
    htb_pkg::t_count  r_lw, n_lw;
    logic [7:0]       r_addr, n_addr;
    logic             r_pend, n_pend;      // count write back pending
    logic             r_ovf_out, n_ovf_out;
    logic [7:0]       r_idx, n_idx;
    logic             r_ordy, n_ordy;      // read index in range
    logic             r_valid, n_valid;
    logic [8:0]       r_o_l, n_o_l, r_o_r, n_o_r, r_o_lc, n_o_lc, r_o_rt, n_o_rt;
    logic [31:0]      r_o_w, n_o_w;
    logic             r_o_ov, n_o_ov;

    logic             accept;
    htb_pkg::t_func   func;
    htb_pkg::t_count  qw_rd;
    htb_pkg::t_id     qid_rd;
    htb_pkg::t_count  sumw;

    assign func   = htb_pkg::t_func'(i_func);
    assign accept = i_start && !o_busy;
    assign qid_rd = r_q_rdata[QW-1 -: htb_pkg::ID_W];
    assign qw_rd  = r_q_rdata[htb_pkg::COUNT_WIDTH-1:0];
    assign sumw   = r_lw + qw_rd;
    assign o_busy = (r_state != htb_pkg::ST_IDLE) || r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htb_pkg::ST_INIT;
            r_sym   <= '0;
            r_qlen  <= '0;
            r_icnt  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sym   <= n_sym;
            r_qlen  <= n_qlen;
            r_icnt  <= n_icnt;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_leaves <= n_leaves; r_w <= n_w; r_id <= n_id;
        r_left <= n_left; r_lw <= n_lw; r_addr <= n_addr; r_ovf_out <= n_ovf_out;
        r_idx <= n_idx; r_ordy <= n_ordy;
        r_o_l <= n_o_l; r_o_r <= n_o_r; r_o_w <= n_o_w; r_o_lc <= n_o_lc;
        r_o_rt <= n_o_rt; r_o_ov <= n_o_ov;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htb_pkg::ST_IDLE: begin
                if (accept && func == htb_pkg::FUNC_BUILD) begin
                    n_state = htb_pkg::ST_SCAN_RD;
                end else if (accept && func == htb_pkg::FUNC_READ) begin
                    n_state = htb_pkg::ST_READ;
                end
            end
            htb_pkg::ST_INIT: begin
                if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                    n_state = htb_pkg::ST_IDLE;
                end
            end
            htb_pkg::ST_SCAN_RD:    n_state = htb_pkg::ST_SCAN;
            htb_pkg::ST_SCAN: begin
                if (r_h_rdata != '0) begin
                    n_state = (r_qlen == '0) ? htb_pkg::ST_INS : htb_pkg::ST_INS_RD;
                end else if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                    n_state = (r_qlen > 9'd1) ? htb_pkg::ST_M_RD0 : htb_pkg::ST_CLEAR;
                end else begin
                    n_state = htb_pkg::ST_SCAN_RD;
                end
            end
            htb_pkg::ST_INS_RD:     n_state = htb_pkg::ST_INS;
            htb_pkg::ST_INS: begin
                if (r_i == '0 || qw_rd <= r_w) begin
                    if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                        n_state = (r_qlen + 9'd1 > 9'd1) ? htb_pkg::ST_M_RD0
                                                          : htb_pkg::ST_CLEAR;
                    end else begin
                        n_state = htb_pkg::ST_SCAN_RD;
                    end
                end else begin
                    n_state = htb_pkg::ST_INS_RD;
                end
            end
            htb_pkg::ST_M_RD0:      n_state = htb_pkg::ST_M_RD1;
            htb_pkg::ST_M_RD1:      n_state = htb_pkg::ST_M_POP;
            htb_pkg::ST_M_POP:      n_state = htb_pkg::ST_M_FIND;
            htb_pkg::ST_M_FIND: begin
                if (r_i + 9'd2 >= r_qlen || qw_rd >= r_w) begin
                    n_state = htb_pkg::ST_M_SHIFT_RD;
                end
            end
            htb_pkg::ST_M_SHIFT_RD: n_state = htb_pkg::ST_M_SHIFT;
            htb_pkg::ST_M_SHIFT: begin
                if (r_i == r_sym) begin
                    if (r_i + 9'd2 >= r_qlen) begin
                        n_state = (r_qlen - 9'd1 > 9'd1) ? htb_pkg::ST_M_RD0
                                                          : htb_pkg::ST_CLEAR;
                    end else begin
                        n_state = htb_pkg::ST_M_TAIL_RD;
                    end
                end else begin
                    n_state = htb_pkg::ST_M_SHIFT_RD;
                end
            end
            htb_pkg::ST_M_TAIL_RD:  n_state = htb_pkg::ST_M_TAIL;
            htb_pkg::ST_M_TAIL: begin
                if (r_i + 9'd2 >= r_qlen) begin
                    n_state = (r_qlen - 9'd1 > 9'd1) ? htb_pkg::ST_M_RD0
                                                      : htb_pkg::ST_CLEAR;
                end else begin
                    n_state = htb_pkg::ST_M_TAIL_RD;
                end
            end
            htb_pkg::ST_CLEAR: begin
                if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                    n_state = htb_pkg::ST_DONE;
                end
            end
            htb_pkg::ST_DONE:       n_state = htb_pkg::ST_IDLE;
            htb_pkg::ST_READ:       n_state = htb_pkg::ST_READ_OUT;
            htb_pkg::ST_READ_OUT:   n_state = htb_pkg::ST_IDLE;
            default:                n_state = htb_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_sym = r_sym; n_qlen = r_qlen; n_i = r_i; n_leaves = r_leaves;
        n_icnt = r_icnt; n_total = r_total; n_ovf = r_ovf; n_w = r_w;
        n_id = r_id; n_left = r_left; n_lw = r_lw; n_addr = r_addr;
        n_pend = 1'b0; n_ovf_out = r_ovf_out; n_idx = r_idx; n_ordy = r_ordy;
        n_valid = 1'b0;
        n_o_l = r_o_l; n_o_r = r_o_r; n_o_w = r_o_w; n_o_lc = r_o_lc;
        n_o_rt = r_o_rt; n_o_ov = r_o_ov;
        h_we = 1'b0; h_waddr = r_addr; h_wdata = r_h_rdata + htb_pkg::t_count'(1);
        h_raddr = i_data_byte;
        q_we = 1'b0; q_waddr = r_i[7:0]; q_wdata = {r_id, r_w}; q_raddr = '0;
        nd_we = 1'b0; nd_waddr = r_icnt[7:0];
        nd_wdata = {r_left, qid_rd, sumw}; nd_raddr = r_idx;

        if (r_pend) begin
            h_we = 1'b1;
        end

        unique case (r_state)
            htb_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (func)
                        htb_pkg::FUNC_COUNT: begin
                            if (r_total == '1) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_total = r_total + htb_pkg::t_count'(1);
                                n_pend  = 1'b1;
                                n_addr  = i_data_byte;
                            end
                        end
                        htb_pkg::FUNC_BUILD: begin
                            n_sym = '0; n_qlen = '0; n_icnt = '0;
                            n_ovf_out = r_ovf;
                        end
                        htb_pkg::FUNC_READ: begin
                            n_idx  = i_node_index;
                            n_ordy = {1'b0, i_node_index} < r_icnt;
                        end
                        default: ;
                    endcase
                end
            end
            htb_pkg::ST_SCAN_RD: h_raddr = r_sym[7:0];
            htb_pkg::ST_SCAN: begin
                n_w  = r_h_rdata;
                n_id = r_sym;
                n_i  = r_qlen;
                q_raddr = 8'(r_qlen - 9'd1);
                if (r_h_rdata == '0) begin
                    n_sym = r_sym + 9'd1;
                end
                if (r_h_rdata == '0 && r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                    n_leaves = r_qlen;
                    n_sym = '0;
                end
            end
            htb_pkg::ST_INS_RD: q_raddr = 8'(r_i - 9'd1);
            htb_pkg::ST_INS: begin
                q_we = 1'b1;
                if (r_i == '0 || qw_rd <= r_w) begin
                    n_qlen = r_qlen + 9'd1;
                    n_sym  = r_sym + 9'd1;
                    if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                        n_leaves = r_qlen + 9'd1;
                        n_sym = '0;
                    end
                end else begin
                    q_wdata = r_q_rdata;
                    n_i = r_i - 9'd1;
                end
            end
            htb_pkg::ST_M_RD0: q_raddr = 8'd0;
            htb_pkg::ST_M_RD1: begin
                q_raddr = 8'd1;
                n_left = qid_rd;
                n_lw   = qw_rd;
            end
            htb_pkg::ST_M_POP: begin
                // Queue entries from index 2 on stay in place; r_i walks them.
                nd_we = 1'b1;
                n_w   = sumw;
                n_id  = htb_pkg::t_id'(htb_pkg::SYMBOLS) + r_icnt;
                n_icnt = r_icnt + 9'd1;
                n_i   = '0;
                q_raddr = 8'd2;
            end
            htb_pkg::ST_M_FIND: begin
                if (r_i + 9'd2 >= r_qlen || qw_rd >= r_w) begin
                    // Shift entries [2, 2+pos) down by two, then shift rest by one.
                    n_sym = r_i;      // final position
                    n_i   = '0;
                    q_raddr = 8'd2;
                end else begin
                    n_i = r_i + 9'd1;
                    q_raddr = 8'(r_i + 9'd3);
                end
            end
            htb_pkg::ST_M_SHIFT_RD: begin
                q_raddr = 8'(r_i + 9'd2);
            end
            htb_pkg::ST_M_SHIFT: begin
                q_we = 1'b1;
                if (r_i == r_sym) begin
                    q_waddr = r_i[7:0];
                    q_wdata = {r_id, r_w};
                    n_i = r_i + 9'd1;
                    if (r_i + 9'd2 >= r_qlen) begin
                        n_qlen = r_qlen - 9'd1;
                        n_sym = '0;
                    end
                end else begin
                    q_waddr = r_i[7:0];
                    q_wdata = r_q_rdata;
                    n_i = r_i + 9'd1;
                end
            end
            htb_pkg::ST_M_TAIL_RD: begin
                q_raddr = 8'(r_i + 9'd1);
            end
            htb_pkg::ST_M_TAIL: begin
                q_we = 1'b1;
                q_waddr = r_i[7:0];
                q_wdata = r_q_rdata;
                if (r_i + 9'd2 >= r_qlen) begin
                    n_qlen = r_qlen - 9'd1;
                    n_sym = '0;
                end else begin
                    n_i = r_i + 9'd1;
                end
            end
            htb_pkg::ST_CLEAR, htb_pkg::ST_INIT: begin
                h_we = 1'b1;
                h_waddr = r_sym[7:0];
                h_wdata = '0;
                n_sym = r_sym + 9'd1;
                q_raddr = 8'd0;
                if (r_sym == 9'(htb_pkg::SYMBOLS - 1)) begin
                    n_sym = '0;
                end
            end
            htb_pkg::ST_DONE: begin
                n_valid = 1'b1;
                n_o_l = '0; n_o_r = '0;
                n_o_lc = r_leaves;
                n_o_w  = (r_qlen == 9'd1) ? 32'(qw_rd) : '0;
                n_o_rt = (r_qlen == 9'd1) ? qid_rd : '0;
                n_o_ov = r_ovf_out;
                n_total = '0;
                n_ovf = 1'b0;
            end
            htb_pkg::ST_READ: nd_raddr = r_idx;
            htb_pkg::ST_READ_OUT: begin
                n_valid = 1'b1;
                n_o_lc = '0; n_o_rt = '0; n_o_ov = r_ovf;
                n_o_l = r_ordy ? r_nd_rdata[NW-1 -: htb_pkg::ID_W] : '0;
                n_o_r = r_ordy ? r_nd_rdata[NW-htb_pkg::ID_W-1 -: htb_pkg::ID_W] : '0;
                n_o_w = r_ordy ? 32'(r_nd_rdata[htb_pkg::COUNT_WIDTH-1:0]) : '0;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_left_child  = r_o_l;
    assign o_right_child = r_o_r;
    assign o_weight      = r_o_w;
    assign o_leaf_count  = r_o_lc;
    assign o_root_node   = r_o_rt;
    assign o_overflow    = r_o_ov;

endmodule
